// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// clocked assertion helpers used by scs_back
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled during reset
`define SCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked property, also checked during reset
`define SCS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- design/scs_pkg.sv -----
// ----------------------------------------------------------------------------
// scs_pkg
// shared types and constants of the completion context scanner
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package scs_pkg;

  localparam int unsigned ColBits = 20;

  // block kinds held on the stack
  typedef enum logic [2:0] {
    KIND_STRUCT    = 3'd0,
    KIND_INTERFACE = 3'd1,
    KIND_ENUM      = 3'd2,
    KIND_UNION_GRP = 3'd3,
    KIND_OPAQUE    = 3'd4,
    KIND_NONE      = 3'd7
  } kind_e;

  // stack operation requested by the front
  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_PUSH = 2'd1,
    OP_POP  = 2'd2
  } op_e;

  // result status; lookup means the back decides from the stack
  typedef enum logic [2:0] {
    ST_OFFER   = 3'd0,
    ST_LITERAL = 3'd1,
    ST_ORDINAL = 3'd2,
    ST_MID     = 3'd3,
    ST_CLOSED  = 3'd4,
    ST_DEEP    = 3'd5,
    ST_LOOKUP  = 3'd6
  } status_e;

  // keyword sets
  localparam logic [1:0] KSET_DECL   = 2'd0;
  localparam logic [1:0] KSET_STRUCT = 2'd1;
  localparam logic [1:0] KSET_UNION  = 2'd2;

  // item passed from front to back
  typedef struct packed {
    op_e                  op;
    kind_e                kind;
    logic                 res;
    status_e              status;
    logic [ColBits-1:0]   line;
    logic [ColBits-1:0]   start_col;
    logic [ColBits-1:0]   end_col;
  } cmd_t;

  // result item
  typedef struct packed {
    logic [ColBits-1:0]   end_col;
    logic [ColBits-1:0]   start_col;
    logic [ColBits-1:0]   line;
    logic [1:0]           kset;
    status_e              status;
  } res_t;

endpackage

// ----- design/schema_completion_context_scanner.sv -----
// path: a cursor item goes through the queue and then the result register of the back
// throughput: one text byte per cycle while the two-entry queue, which decouples the
// lexer, is not full; the back updates the stack and looks up each item it takes
// reset: asynchronous active-low; lexer, nesting count and queue clear at once,
// stack and word storage are written before they are read
// ----------------------------------------------------------------------------
// schema_completion_context_scanner
// keyword completion context of schema text up to the cursor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module schema_completion_context_scanner #(
  parameter int unsigned STACK_DEPTH   = 32,
  parameter int unsigned POSITION_BITS = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // text_byte[7:0], cursor_line[27:8], cursor_column[47:28]
  input  logic [47:0] s_axis_tdata,
  // at_cursor
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[2:0], keyword_set[4:3], replace_line[24:5],
  // replace_start_column[44:25], replace_end_column[64:45], zero fill
  output logic [71:0] m_axis_tdata
);
  import scs_pkg::*;

  logic q_push, q_full, q_pop, q_valid;
  cmd_t f_cmd, b_cmd;
  res_t res;

  // lexer front
  scs_front #(.POSITION_BITS(POSITION_BITS)) u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (s_axis_tvalid),
    .in_ready_i_unused_o (s_axis_tready),
    .text_byte_i         (s_axis_tdata[7:0]),
    .at_cursor_i         (s_axis_tlast),
    .cursor_line_i       (s_axis_tdata[27:8]),
    .cursor_column_i     (s_axis_tdata[47:28]),
    .q_full_i            (q_full),
    .q_push_o            (q_push),
    .q_cmd_o             (f_cmd)
  );

  // decoupling queue
  scs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (f_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (b_cmd)
  );

  // stack back
  scs_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (b_cmd),
    .cmd_pop_o   (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = {7'd0, res};

endmodule

// ----- design/scs_front.sv -----
// ----------------------------------------------------------------------------
// scs_front
// lexer: tracks mode, words, statement tokens and positions per text byte
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scs_front #(
  parameter int unsigned POSITION_BITS = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_i_unused_o,
  input  logic [7:0]                    text_byte_i,
  input  logic                          at_cursor_i,
  input  logic [scs_pkg::ColBits-1:0]   cursor_line_i,
  input  logic [scs_pkg::ColBits-1:0]   cursor_column_i,
  input  logic                          q_full_i,
  output logic                          q_push_o,
  output scs_pkg::cmd_t                 q_cmd_o
);
  import scs_pkg::*;

  localparam int unsigned P = POSITION_BITS;
  localparam int unsigned W = (P > ColBits) ? P : ColBits;
  localparam logic [P-1:0] PosMax = {P{1'b1}};

  typedef enum logic [1:0] {
    MODE_CODE    = 2'd0,
    MODE_COMMENT = 2'd1,
    MODE_STRING  = 2'd2
  } mode_e;

  function automatic logic is_ident(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_" ||
           (c >= "0" && c <= "9");
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0d || c == 8'h0a;
  endfunction

  mode_e        mode_q, mode_d;
  logic         esc_q, esc_d;
  kind_e        pend_q, pend_d;
  logic [7:0]   wc_q [9];
  logic [3:0]   wl_q, wl_d;
  logic         wc_we;
  logic [1:0]   st_q, st_d;
  logic [P-1:0] bp_q, bp_d, ftp_q, ftp_d, ir_q, ir_d;
  logic [7:0]   bbr_q, bbr_d;
  logic         cnt;
  logic         take;
  logic [7:0]   c;
  op_e          op;
  kind_e        kind;
  status_e      status;
  logic         at_start;
  logic [W-1:0] ir_w, col_w;

  assign c    = text_byte_i;
  assign take = in_valid_i && !q_full_i;
  assign in_ready_i_unused_o = !q_full_i;

  // next lexer state for the byte
  always_comb begin
    mode_d = mode_q;
    esc_d  = esc_q;
    pend_d = pend_q;
    wl_d   = wl_q;
    st_d   = st_q;
    ftp_d  = ftp_q;
    wc_we  = 1'b0;
    cnt    = 1'b0;
    op     = OP_NONE;
    kind   = KIND_OPAQUE;
    unique case (mode_q)
      MODE_COMMENT: begin
        if (c == 8'h0a) mode_d = MODE_CODE;
      end
      MODE_STRING: begin
        if (esc_q) esc_d = 1'b0;
        else if (c == "\\") esc_d = 1'b1;
        else if (c == "\"" || c == 8'h0a) mode_d = MODE_CODE;
      end
      default: begin
        if (is_ident(c)) begin
          if (wl_q == 4'd0) cnt = 1'b1;
          if (wl_q < 4'd9) wc_we = 1'b1;
          if (wl_q <= 4'd9) wl_d = wl_q + 4'd1;
        end else begin
          // close the word and match keywords
          if (wl_q != 4'd0) begin
            if (wl_q == 4'd6 && wc_q[0] == "s" && wc_q[1] == "t" && wc_q[2] == "r" &&
                wc_q[3] == "u" && wc_q[4] == "c" && wc_q[5] == "t")
              pend_d = KIND_STRUCT;
            else if (wl_q == 4'd9 && wc_q[0] == "i" && wc_q[1] == "n" && wc_q[2] == "t" &&
                     wc_q[3] == "e" && wc_q[4] == "r" && wc_q[5] == "f" &&
                     wc_q[6] == "a" && wc_q[7] == "c" && wc_q[8] == "e")
              pend_d = KIND_INTERFACE;
            else if (wl_q == 4'd4 && wc_q[0] == "e" && wc_q[1] == "n" && wc_q[2] == "u" &&
                     wc_q[3] == "m")
              pend_d = KIND_ENUM;
            else if (wl_q == 4'd5 && ((wc_q[0] == "u" && wc_q[1] == "n" && wc_q[2] == "i" &&
                     wc_q[3] == "o" && wc_q[4] == "n") ||
                     (wc_q[0] == "g" && wc_q[1] == "r" && wc_q[2] == "o" &&
                     wc_q[3] == "u" && wc_q[4] == "p")))
              pend_d = KIND_UNION_GRP;
            wl_d = 4'd0;
          end
          case (c)
            "#": mode_d = MODE_COMMENT;
            "\"": begin
              cnt    = 1'b1;
              mode_d = MODE_STRING;
            end
            ";": begin
              st_d   = 2'd0;
              pend_d = KIND_NONE;
            end
            "{": begin
              op     = OP_PUSH;
              kind   = (pend_d == KIND_NONE) ? KIND_OPAQUE : pend_d;
              pend_d = KIND_NONE;
              st_d   = 2'd0;
            end
            "}": begin
              op     = OP_POP;
              pend_d = KIND_NONE;
              st_d   = 2'd0;
            end
            default: begin
              if (!is_space(c)) cnt = 1'b1;
            end
          endcase
        end
        // token count of the statement
        if (cnt) begin
          if (st_q == 2'd0) ftp_d = bp_q;
          if (st_q < 2'd2) st_d = st_q + 2'd1;
        end
      end
    endcase
    bp_d = (bp_q < PosMax) ? bp_q + P'(1) : bp_q;
    if (is_ident(c)) begin
      ir_d  = (ir_q < PosMax) ? ir_q + P'(1) : ir_q;
      bbr_d = bbr_q;
    end else begin
      ir_d  = '0;
      bbr_d = c;
    end
  end

  // cursor classification on the updated state
  always_comb begin
    at_start = (ir_d == '0) ? (st_d == 2'd0) : (st_d == 2'd1 && ftp_d == bp_d - ir_d);
    if (mode_d != MODE_CODE) status = ST_LITERAL;
    else if (bp_d > ir_d && bbr_d == "@") status = ST_ORDINAL;
    else if (!at_start) status = ST_MID;
    else status = ST_LOOKUP;
    ir_w  = W'(ir_d);
    col_w = W'(cursor_column_i);
  end

  // item to the queue
  always_comb begin
    q_push_o          = take;
    q_cmd_o.op        = op;
    q_cmd_o.kind      = kind;
    q_cmd_o.res       = at_cursor_i;
    q_cmd_o.status    = status;
    q_cmd_o.line      = cursor_line_i;
    q_cmd_o.start_col = (ir_w >= col_w) ? '0 : ColBits'(col_w - ir_w);
    q_cmd_o.end_col   = cursor_column_i;
  end

  // lexer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_CODE;
      esc_q  <= 1'b0;
      pend_q <= KIND_NONE;
      wl_q   <= 4'd0;
      st_q   <= 2'd0;
      bp_q   <= '0;
      ftp_q  <= '0;
      ir_q   <= '0;
      bbr_q  <= 8'd0;
    end else if (take) begin
      mode_q <= mode_d;
      esc_q  <= esc_d;
      pend_q <= pend_d;
      wl_q   <= wl_d;
      st_q   <= st_d;
      bp_q   <= bp_d;
      ftp_q  <= ftp_d;
      ir_q   <= ir_d;
      bbr_q  <= bbr_d;
    end
  end

  // word characters
  always_ff @(posedge clk_i) begin
    if (take && wc_we) begin
      wc_q[wl_q] <= c;
    end
  end

endmodule

// ----- design/scs_queue.sv -----
// ----------------------------------------------------------------------------
// scs_queue
// two-entry queue between lexer front and stack back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scs_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  scs_pkg::cmd_t  cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output scs_pkg::cmd_t  cmd_o
);
  import scs_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = mem_q[rd_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

// ----- design/scs_back.sv -----
// ----------------------------------------------------------------------------
// scs_back
// block stack, nesting count and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scs_back #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  scs_pkg::cmd_t  cmd_i,
  output logic           cmd_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output scs_pkg::res_t  out_o
);
  import scs_pkg::*;

  localparam int unsigned SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic [15:0] Depth = 16'(STACK_DEPTH);

  kind_e       stack_q [STACK_DEPTH];
  logic [15:0] nest_q, nest_d;
  logic        out_vld_q;
  res_t        out_q, res;
  logic        take;
  kind_e       top;
  logic [15:0] rd_idx;

  assign take        = cmd_valid_i && (!cmd_i.res || !out_vld_q || out_ready_i);
  assign cmd_pop_o   = take;
  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

  // nesting after this item
  always_comb begin
    nest_d = nest_q;
    case (cmd_i.op)
      OP_PUSH: if (nest_q != 16'hffff) nest_d = nest_q + 16'd1;
      OP_POP:  if (nest_q != 16'd0) nest_d = nest_q - 16'd1;
      default: nest_d = nest_q;
    endcase
    rd_idx = nest_d - 16'd1;
    if (cmd_i.op == OP_PUSH) top = cmd_i.kind;
    else top = stack_q[rd_idx[SW-1:0]];
  end

  // result from the nesting count and the stack top
  always_comb begin
    res.status    = cmd_i.status;
    res.kset      = KSET_DECL;
    res.line      = cmd_i.line;
    res.start_col = cmd_i.start_col;
    res.end_col   = cmd_i.end_col;
    if (cmd_i.status == ST_LOOKUP) begin
      if (nest_d > Depth) res.status = ST_DEEP;
      else if (nest_d == 16'd0) res.status = ST_OFFER;
      else begin
        case (top)
          KIND_STRUCT: begin
            res.status = ST_OFFER;
            res.kset   = KSET_STRUCT;
          end
          KIND_INTERFACE: res.status = ST_OFFER;
          KIND_UNION_GRP: begin
            res.status = ST_OFFER;
            res.kset   = KSET_UNION;
          end
          default: res.status = ST_CLOSED;
        endcase
      end
    end
    if (res.status != ST_OFFER) begin
      res.kset      = 2'd0;
      res.line      = '0;
      res.start_col = '0;
      res.end_col   = '0;
    end
  end

  // nesting count and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nest_q    <= 16'd0;
      out_vld_q <= 1'b0;
    end else begin
      if (take) nest_q <= nest_d;
      if (take && cmd_i.res) out_vld_q <= 1'b1;
      else if (out_ready_i) out_vld_q <= 1'b0;
    end
  end

  // stack writes and result payload
  always_ff @(posedge clk_i) begin
    if (take && cmd_i.op == OP_PUSH && nest_q < Depth) begin
      stack_q[nest_q[SW-1:0]] <= cmd_i.kind;
    end
    if (take && cmd_i.res) begin
      out_q <= res;
    end
  end

  `SCS_ASSERT(a_nest_hold, take && cmd_i.op == OP_NONE |=> $stable(nest_q), "nesting moved")
  `SCS_ASSERT(a_nest_up, take && cmd_i.op != OP_PUSH |=> nest_q <= $past(nest_q), "nesting grew")
  `SCS_ASSERT(a_no_offer_zero, out_vld_q && out_q.status != ST_OFFER |-> out_q.kset == 2'd0 && out_q.line == '0 && out_q.end_col == '0, "fields not cleared")

endmodule

// ----- verif/schema_completion_context_scanner_test.sv -----
// ----------------------------------------------------------------------------
// schema_completion_context_scanner_test
// streams schema text through the scanner, predicts each cursor result with
// an in-bench lexer and stack model, and checks results field by field under
// several sender and receiver idling mixes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module schema_completion_context_scanner_test;
  import scs_pkg::*;

  localparam int unsigned Depth = 32;
  localparam logic [19:0] PosMax = 20'hFFFFF;
  localparam logic [1:0] LexCode = 2'd0;
  localparam logic [1:0] LexComment = 2'd1;
  localparam logic [1:0] LexString = 2'd2;
  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    logic [19:0] end_col;
    logic [19:0] start_col;
    logic [19:0] line;
    logic [1:0]  kset;
    logic [2:0]  status;
  } outcome_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;

  schema_completion_context_scanner uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // scanner state mirror
  logic [1:0]  lex_mode;
  logic        esc_skip;
  kind_e       kinds [Depth];
  logic [15:0] depth_cnt;
  kind_e       pend_kind;
  logic [7:0]  word [9];
  logic [3:0]  word_len;
  logic [1:0]  stmt_tokens;
  logic [19:0] byte_pos;
  logic [19:0] first_tok_pos;
  logic [19:0] run_len;
  logic [7:0]  byte_before;

  outcome_t expected_q[$];
  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  int unsigned cycle_cnt;
  bit failed;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic bit is_ident(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_" ||
           (c >= "0" && c <= "9");
  endfunction

  function automatic bit word_matches(string kw);
    if (word_len != kw.len()) return 0;
    for (int i = 0; i < kw.len(); i++) begin
      if (word[i] != kw[i]) return 0;
    end
    return 1;
  endfunction

  function automatic void close_word();
    if (word_len == 0) return;
    if (word_matches("struct")) pend_kind = KIND_STRUCT;
    else if (word_matches("interface")) pend_kind = KIND_INTERFACE;
    else if (word_matches("enum")) pend_kind = KIND_ENUM;
    else if (word_matches("union") || word_matches("group")) pend_kind = KIND_UNION_GRP;
    word_len = 0;
  endfunction

  function automatic void note_token(logic [19:0] here);
    if (stmt_tokens == 0) first_tok_pos = here;
    if (stmt_tokens < 2) stmt_tokens++;
  endfunction

  function automatic void clear_scanner();
    lex_mode = LexCode;
    esc_skip = 0;
    for (int i = 0; i < Depth; i++) kinds[i] = KIND_STRUCT;
    depth_cnt = 0;
    pend_kind = KIND_NONE;
    for (int i = 0; i < 9; i++) word[i] = 8'd0;
    word_len = 0;
    stmt_tokens = 0;
    byte_pos = 0;
    first_tok_pos = 0;
    run_len = 0;
    byte_before = 8'd0;
  endfunction

  // advance the mirror by one byte; queue a result on a cursor byte
  function automatic void scan_byte(logic [7:0] c, bit cur, logic [19:0] line,
                                    logic [19:0] col);
    logic [19:0] here;
    logic [19:0] pstart;
    outcome_t res;
    bit at_start;
    kind_e top;
    here = byte_pos;
    res = '0;
    if (lex_mode == LexComment) begin
      if (c == 8'h0a) lex_mode = LexCode;
    end else if (lex_mode == LexString) begin
      if (esc_skip) esc_skip = 0;
      else if (c == "\\") esc_skip = 1;
      else if (c == "\"" || c == 8'h0a) lex_mode = LexCode;
    end else if (is_ident(c)) begin
      if (word_len == 0) note_token(here);
      if (word_len < 9) word[word_len] = c;
      if (word_len <= 9) word_len++;
    end else begin
      close_word();
      if (c == "#") begin
        lex_mode = LexComment;
      end else if (c == "\"") begin
        note_token(here);
        lex_mode = LexString;
      end else if (c == ";") begin
        stmt_tokens = 0;
        pend_kind = KIND_NONE;
      end else if (c == "{") begin
        if (depth_cnt < Depth) kinds[depth_cnt] = (pend_kind == KIND_NONE) ? KIND_OPAQUE : pend_kind;
        if (depth_cnt != 16'hFFFF) depth_cnt++;
        pend_kind = KIND_NONE;
        stmt_tokens = 0;
      end else if (c == "}") begin
        if (depth_cnt > 0) depth_cnt--;
        pend_kind = KIND_NONE;
        stmt_tokens = 0;
      end else if (!(c == " " || c == 8'h09 || c == 8'h0d || c == 8'h0a)) begin
        note_token(here);
      end
    end
    if (byte_pos != PosMax) byte_pos++;
    if (is_ident(c)) begin
      if (run_len != PosMax) run_len++;
    end else begin
      run_len = 0;
      byte_before = c;
    end
    if (!cur) return;
    pstart = byte_pos - ((run_len <= byte_pos) ? run_len : byte_pos);
    if (lex_mode != LexCode) res.status = ST_LITERAL;
    else if (byte_pos > run_len && byte_before == "@") res.status = ST_ORDINAL;
    else begin
      at_start = (run_len == 0) ? (stmt_tokens == 0)
                                : (stmt_tokens == 1 && first_tok_pos == pstart);
      if (!at_start) res.status = ST_MID;
      else if (depth_cnt > Depth) res.status = ST_DEEP;
      else if (depth_cnt == 0) begin
        res.status = ST_OFFER;
        res.kset = KSET_DECL;
      end else begin
        top = kinds[(depth_cnt - 1) % Depth];
        res.status = ST_OFFER;
        if (top == KIND_STRUCT) res.kset = KSET_STRUCT;
        else if (top == KIND_INTERFACE) res.kset = KSET_DECL;
        else if (top == KIND_UNION_GRP) res.kset = KSET_UNION;
        else res.status = ST_CLOSED;
      end
    end
    if (res.status == ST_OFFER) begin
      res.line = line;
      res.end_col = col;
      res.start_col = (run_len >= col) ? 20'd0 : col - run_len;
    end
    expected_q.push_back(res);
  endfunction

  // send one item; inputs move on the falling edge
  task automatic send_byte(logic [7:0] c, bit cur = 0, logic [19:0] line = 0,
                           logic [19:0] col = 0);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {col, line, c};
    s_axis_tlast <= cur;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    scan_byte(c, cur, line, col);
    @(negedge clk_i);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_cursor(logic [7:0] c);
    send_byte(c, 1, 20'($urandom), 20'($urandom_range(0, 12)));
  endtask

  // receiver stall pattern
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // result checker
  always @(posedge clk_i) begin
    outcome_t got;
    outcome_t exp_res;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[64:0];
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        failed = 1;
      end else begin
        exp_res = expected_q.pop_front();
        if (got.status != exp_res.status)
          $display("%0t: status exp %0d got %0d", $time, exp_res.status, got.status);
        if (got.kset != exp_res.kset)
          $display("%0t: keyword_set exp %0d got %0d", $time, exp_res.kset, got.kset);
        if (got.line != exp_res.line)
          $display("%0t: replace_line exp %0d got %0d", $time, exp_res.line, got.line);
        if (got.start_col != exp_res.start_col)
          $display("%0t: replace_start_column exp %0d got %0d", $time,
                   exp_res.start_col, got.start_col);
        if (got.end_col != exp_res.end_col)
          $display("%0t: replace_end_column exp %0d got %0d", $time,
                   exp_res.end_col, got.end_col);
        if (got != exp_res) failed = 1;
      end
    end
  end

  // run watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // extremes of fields, cursor in comment, string and escape, ordinal
  task automatic test_directed();
    send_byte(8'hff, 1, 20'hFFFFF, 20'hFFFFF);
    send_byte(8'h0a, 1, 20'd0, 20'd0);
    send_text("struct S {");
    send_byte("a", 1, 20'hFFFFF, 20'hFFFFF);
    send_text(" # x");
    send_cursor("y");
    send_text("\n\"a\\");
    send_cursor(8'h0a);
    send_text("\"; union U { group g {}");
    send_cursor(" ");
    send_text("} x @");
    send_cursor("1");
    send_text("; enum E {");
    send_cursor("z");
    send_text("}}} interface I {");
    send_text("abcdefghijklmno");
    send_cursor("p");
  endtask

  // nesting past the stack capacity and back
  task automatic test_deep_nesting();
    for (int i = 0; i < Depth + 2; i++) begin
      if (i % 2) send_text("struct a{");
      else send_text("{");
    end
    send_cursor("q");
    for (int i = 0; i < Depth + 2; i++) send_byte("}");
    send_cursor(";");
  endtask

  // random statements drawn from schema-like tokens, with noise
  task automatic test_random(int unsigned n_items);
    string toks[] = '{"struct ", "interface ", "enum ", "union ", "group ", "{", "}",
                      ";", " ", "\n", "x", "fooBar_9", "@", "#c\n", "\"s\\\"\"",
                      "Int32", ":", "longerwordhere", "struc", "(", ")"};
    string t;
    int unsigned sent;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        send_byte(8'($urandom));
        sent++;
      end else begin
        t = toks[$urandom_range(toks.size() - 1)];
        send_text(t);
        sent += t.len();
      end
      if ($urandom_range(5) == 0) begin
        send_cursor($urandom_range(1) ? 8'($urandom) : "w");
        sent++;
      end
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  initial begin
    failed = 0;
    cycle_cnt = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b1;
    clear_scanner();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_deep_nesting();
    test_random(215);
    sender_idle_pct = 57;
    test_random(215);
    sender_idle_pct = 0;
    receiver_stall_pct = 57;
    test_random(215);
    sender_idle_pct = 23;
    receiver_stall_pct = 23;
    test_random(215);
    drain();
    if (!failed) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/scs_pkg.sv
design/scs_front.sv
design/scs_queue.sv
design/scs_back.sv
design/schema_completion_context_scanner.sv
verif/schema_completion_context_scanner_test.sv
